@@ rtl/rc_frame_override_mapper_core_macros.svh @@
// Assertion macros shared by the mapper checker.
`ifndef RC_FRAME_OVERRIDE_MAPPER_CORE_MACROS_SVH
`define RC_FRAME_OVERRIDE_MAPPER_CORE_MACROS_SVH

// Checked only while out of reset.
`define RCFM_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rc frame mapper check failed");

// Checked at every edge, reset included.
`define RCFM_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("rc frame mapper check failed");

`endif

@@ rtl/rcfm_pkg.sv @@
// Shared types and constants for the rc frame override mapper.
`timescale 1ns / 1ps
`default_nettype none
package rcfm_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int CHANNELS    = 7;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int CH_W        = $clog2(CHANNELS);

    localparam int CHAN_W      = 10;
    localparam int VEL_W       = 22;
    localparam int FIN_W       = 8;
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_CENTER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_DEADBAND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_THRESH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd3;

    localparam logic [CHAN_W-1:0] RST_THR_CENTER   = 10'd415;
    localparam logic [CHAN_W-1:0] RST_THR_DEADBAND = 10'd20;
    localparam logic [CHAN_W-1:0] RST_GEAR_THRESH  = 10'd500;
    localparam logic [TICK_W-1:0] RST_TIMEOUT      = 16'd2000;

    // channel slots
    localparam int CH_THROTTLE = 0;
    localparam int CH_AILERON  = 1;
    localparam int CH_ELEVATOR = 2;
    localparam int CH_GEAR     = 4;

    // header bytes that pass the check
    localparam logic [7:0] HDR0_OK = 8'h03;
    localparam logic [7:0] HDR1_OK = 8'h01;

    // velocity = floor(|t| * 16106 / 15) == (|t| * VEL_RECIP) >> VEL_SHIFT for |t| <= 1023
    localparam logic [24:0] VEL_RECIP = 25'd17592047;
    localparam int          VEL_SHIFT = 14;

    // fin = floor(d * 5 / 14) == (d * FIN_RECIP) >> FIN_SHIFT for d <= 640
    localparam logic [12:0]       FIN_RECIP = 13'd5852;
    localparam int                FIN_SHIFT = 14;
    localparam logic [CHAN_W-1:0] FIN_MIN   = 10'd180;
    localparam logic [CHAN_W-1:0] FIN_MAX   = 10'd820;

    typedef struct packed {
        logic [CHAN_W-1:0] throttle;
        logic [CHAN_W-1:0] aileron;
        logic [CHAN_W-1:0] elevator;
        logic [CHAN_W-1:0] gear;
    } t_chan;

    typedef struct packed {
        logic frame_end;
        logic hdr_ok;
    } t_frame_evt;

endpackage
`default_nettype wire

@@ rtl/rc_frame_override_mapper_core.sv @@
// Top level of the rc frame override mapper.
`timescale 1ns / 1ps
`default_nettype none
// Takes one frame byte or time tick per transaction and sustains one transaction
// per clock. Each transaction goes through an input register, is decoded combinationally
// (channel store update, header check, timeout and the constant-multiply command math),
// and its result, if any, lands in the output register. A result is produced at the
// last byte of each frame and when a tick drops remote mode. The input stalls only
// while the output register holds a result that is itself stalled.
// Configuration writes are accepted in every cycle (ready held high).
module rc_frame_override_mapper_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output      logic                                o_in_stall,
    input  wire logic                                i_opcode,
    input  wire logic [7:0]                          i_frame_byte,
    input  wire logic                                i_frame_start,
    output      logic                                o_out_valid,
    input  wire logic                                i_out_stall,
    output      logic                                o_remote_active,
    output      logic                                o_frame_accepted,
    output      logic                                o_timed_out,
    output      logic signed [rcfm_pkg::VEL_W-1:0]   o_thruster_velocity,
    output      logic [rcfm_pkg::FIN_W-1:0]          o_rudder_position,
    output      logic [rcfm_pkg::FIN_W-1:0]          o_plane_position,
    input  wire logic                                i_cfg_valid,
    output      logic                                o_cfg_ready,
    input  wire logic [rcfm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rcfm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rcfm_pkg::*;

    // configuration
    logic [CHAN_W-1:0] r_center;
    logic [CHAN_W-1:0] r_deadband;
    logic [CHAN_W-1:0] r_gear_thr;
    logic [TICK_W-1:0] r_timeout;

    // input stage
    logic       r_in_vld;
    logic       r_op;
    logic [7:0] r_byte;
    logic       r_start;

    // block state
    logic                    r_remote;
    logic [TICK_W-1:0]       r_ticks;
    logic signed [VEL_W-1:0] r_vel;
    logic [FIN_W-1:0]        r_rudder;
    logic [FIN_W-1:0]        r_plane;

    // output stage
    logic                    r_out_vld;
    logic                    r_o_remote;
    logic                    r_o_acc;
    logic                    r_o_tout;
    logic signed [VEL_W-1:0] r_o_vel;
    logic [FIN_W-1:0]        r_o_rudder;
    logic [FIN_W-1:0]        r_o_plane;

    logic                    n_remote;
    logic [TICK_W-1:0]       n_ticks;
    logic signed [VEL_W-1:0] n_vel;
    logic [FIN_W-1:0]        n_rudder;
    logic [FIN_W-1:0]        n_plane;
    logic                    n_emit;
    logic                    n_acc;
    logic                    n_tout;

    logic                    w_adv;
    logic                    w_in_acc;
    logic                    w_tick;
    logic                    w_byte_en;
    logic [TICK_W-1:0]       w_ticks_inc;
    t_chan                   w_chan;
    t_frame_evt              w_evt;
    logic signed [VEL_W-1:0] w_cmd_vel;
    logic [FIN_W-1:0]        w_cmd_rudder;
    logic [FIN_W-1:0]        w_cmd_plane;

    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_tick     = w_adv && (r_op == OP_TICK);
    assign w_byte_en  = w_adv && (r_op == OP_BYTE);
    assign o_cfg_ready = 1'b1;

    rcfm_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_byte_en),
        .i_byte  (r_byte),
        .i_start (r_start),
        .o_chan  (w_chan),
        .o_evt   (w_evt)
    );

    rcfm_cmd u_cmd (
        .i_chan     (w_chan),
        .i_center   (r_center),
        .i_deadband (r_deadband),
        .o_velocity (w_cmd_vel),
        .o_rudder   (w_cmd_rudder),
        .o_plane    (w_cmd_plane)
    );

    always_comb begin
        w_ticks_inc = (r_ticks == '1) ? r_ticks : r_ticks + TICK_W'(1);
        n_remote = r_remote;
        n_ticks  = r_ticks;
        n_vel    = r_vel;
        n_rudder = r_rudder;
        n_plane  = r_plane;
        n_emit   = 1'b0;
        n_acc    = 1'b0;
        n_tout   = 1'b0;
        if (w_tick) begin
            n_ticks = w_ticks_inc;
            if (r_remote && (w_ticks_inc > r_timeout)) begin
                n_remote = 1'b0;
                n_emit   = 1'b1;
                n_tout   = 1'b1;
            end
        end else if (w_evt.frame_end) begin
            n_emit = 1'b1;
            if (w_evt.hdr_ok) begin
                n_acc = 1'b1;
                if (w_chan.gear > r_gear_thr) begin
                    n_remote = 1'b1;
                    n_ticks  = '0;
                    n_vel    = w_cmd_vel;
                    n_rudder = w_cmd_rudder;
                    n_plane  = w_cmd_plane;
                end else begin
                    n_remote = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center   <= RST_THR_CENTER;
            r_deadband <= RST_THR_DEADBAND;
            r_gear_thr <= RST_GEAR_THRESH;
            r_timeout  <= RST_TIMEOUT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_THR_CENTER:   r_center   <= i_cfg_data[CHAN_W-1:0];
                CFG_THR_DEADBAND: r_deadband <= i_cfg_data[CHAN_W-1:0];
                CFG_GEAR_THRESH:  r_gear_thr <= i_cfg_data[CHAN_W-1:0];
                CFG_TIMEOUT:      r_timeout  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_opcode;
            r_byte  <= i_frame_byte;
            r_start <= i_frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote <= 1'b0;
            r_ticks  <= '0;
            r_vel    <= '0;
            r_rudder <= '0;
            r_plane  <= '0;
        end else if (w_adv) begin
            r_remote <= n_remote;
            r_ticks  <= n_ticks;
            r_vel    <= n_vel;
            r_rudder <= n_rudder;
            r_plane  <= n_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && n_emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && n_emit) begin
            r_o_remote <= n_remote;
            r_o_acc    <= n_acc;
            r_o_tout   <= n_tout;
            r_o_vel    <= n_vel;
            r_o_rudder <= n_rudder;
            r_o_plane  <= n_plane;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_remote_active     = r_o_remote;
    assign o_frame_accepted    = r_o_acc;
    assign o_timed_out         = r_o_tout;
    assign o_thruster_velocity = r_o_vel;
    assign o_rudder_position   = r_o_rudder;
    assign o_plane_position    = r_o_plane;

endmodule
`default_nettype wire

@@ rtl/rcfm_frame.sv @@
// Frame assembler: byte position, header, pair assembly and channel store.
`timescale 1ns / 1ps
`default_nettype none
module rcfm_frame (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic [7:0]               i_byte,
    input  wire logic                     i_start,
    output      rcfm_pkg::t_chan          o_chan,
    output      rcfm_pkg::t_frame_evt     o_evt
);
    import rcfm_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [7:0]        r_hdr0;
    logic [7:0]        r_hdr1;
    logic [7:0]        r_pend;
    logic [CHAN_W-1:0] r_store [CHANNELS];
    logic [CHAN_W-1:0] n_store [CHANNELS];

    logic [POS_W-1:0]  w_pos;
    logic              w_hdr_ok;
    logic [5:0]        w_id;
    logic              w_wr;

    always_comb begin
        w_pos    = i_start ? '0 : r_pos;
        w_hdr_ok = (r_hdr0 == HDR0_OK) || (r_hdr1 == HDR1_OK);
        w_id     = r_pend[7:2];
        w_wr     = i_en && (w_pos >= POS_W'(2)) && w_pos[0] && w_hdr_ok
                   && (w_id < 6'(CHANNELS));
        n_store  = r_store;
        if (w_wr) begin
            n_store[w_id[CH_W-1:0]] = {r_pend[1:0], i_byte};
        end
    end

    // downstream sees the store including the pair that completes now
    assign o_chan.throttle = n_store[CH_THROTTLE];
    assign o_chan.aileron  = n_store[CH_AILERON];
    assign o_chan.elevator = n_store[CH_ELEVATOR];
    assign o_chan.gear     = n_store[CH_GEAR];
    assign o_evt.frame_end = i_en && (w_pos == POS_W'(FRAME_BYTES - 1));
    assign o_evt.hdr_ok    = w_hdr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hdr0 <= '0;
            r_hdr1 <= '0;
            r_pend <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_en) begin
            r_pos <= w_pos + POS_W'(1);
            if (w_pos == POS_W'(0)) begin
                r_hdr0 <= i_byte;
            end
            if (w_pos == POS_W'(1)) begin
                r_hdr1 <= i_byte;
            end
            if ((w_pos >= POS_W'(2)) && !w_pos[0]) begin
                r_pend <= i_byte;
            end
            r_store <= n_store;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rcfm_cmd.sv @@
// Command math: thruster velocity with deadband, fin positions with clamp.
`timescale 1ns / 1ps
`default_nettype none
module rcfm_cmd (
    input  wire rcfm_pkg::t_chan                    i_chan,
    input  wire logic [rcfm_pkg::CHAN_W-1:0]        i_center,
    input  wire logic [rcfm_pkg::CHAN_W-1:0]        i_deadband,
    output      logic signed [rcfm_pkg::VEL_W-1:0]  o_velocity,
    output      logic [rcfm_pkg::FIN_W-1:0]         o_rudder,
    output      logic [rcfm_pkg::FIN_W-1:0]         o_plane
);
    import rcfm_pkg::*;

    function automatic logic [FIN_W-1:0] fin_pos(input logic [CHAN_W-1:0] c);
        logic [CHAN_W-1:0] cc;
        logic [22:0]       p;
        if (c > FIN_MAX) begin
            cc = FIN_MAX;
        end else if (c < FIN_MIN) begin
            cc = FIN_MIN;
        end else begin
            cc = c;
        end
        p = 23'(cc - FIN_MIN) * 23'(FIN_RECIP);
        return p[FIN_SHIFT +: FIN_W];
    endfunction

    logic signed [CHAN_W:0] w_t;
    logic [CHAN_W-1:0]      w_mag;
    logic                   w_dead;
    logic [34:0]            w_prod;
    logic [VEL_W-2:0]       w_q;

    always_comb begin
        w_t    = $signed({1'b0, i_chan.throttle}) - $signed({1'b0, i_center});
        w_mag  = w_t[CHAN_W] ? CHAN_W'(-w_t) : w_t[CHAN_W-1:0];
        w_dead = w_mag < i_deadband;
        w_prod = 35'(w_mag) * 35'(VEL_RECIP);
        w_q    = w_prod[VEL_SHIFT +: VEL_W-1];
        if (w_dead) begin
            o_velocity = '0;
        end else if (w_t[CHAN_W]) begin
            o_velocity = $signed(VEL_W'(0) - {1'b0, w_q});
        end else begin
            o_velocity = $signed({1'b0, w_q});
        end
        o_rudder = fin_pos(i_chan.aileron);
        o_plane  = fin_pos(i_chan.elevator);
    end

endmodule
`default_nettype wire

@@ rtl/rcfm_chk.sv @@
// Port-level checker for the rc frame override mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rc_frame_override_mapper_core_macros.svh"
module rcfm_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_remote_active,
    input wire logic       o_frame_accepted,
    input wire logic       o_timed_out,
    input wire logic [7:0] o_rudder_position,
    input wire logic [7:0] o_plane_position
);

    // a stalled result stays offered
    `RCFM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)

    // a timeout report is never also a frame report, and always drops remote mode
    `RCFM_ASSERT(a_tout_excl, i_clk, i_rst_n, o_out_valid && o_timed_out |-> !o_remote_active && !o_frame_accepted)

    // fin outputs stay within the mapped range of the clamp
    `RCFM_ASSERT(a_fin_range, i_clk, i_rst_n, o_out_valid |-> o_rudder_position <= 8'd228 && o_plane_position <= 8'd228)

    // no result right after reset
    `RCFM_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind rc_frame_override_mapper_core rcfm_chk u_rcfm_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_remote_active   (o_remote_active),
    .o_frame_accepted  (o_frame_accepted),
    .o_timed_out       (o_timed_out),
    .o_rudder_position (o_rudder_position),
    .o_plane_position  (o_plane_position)
);
`default_nettype wire
